@@ sv/dlle_pkg.sv @@
`timescale 1ns / 1ps

package dlle_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DEL_FIRST,
        OP_DEL_LAST,
        OP_DEL_KEY
    } dlle_op_t;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_EMPTY,
        STATUS_FULL
    } dlle_status_t;

    typedef struct packed {
        dlle_op_t           kind;
        logic signed [31:0] key;
    } dlle_req_t;

    typedef struct packed {
        dlle_status_t       status;
        logic [8:0]         entry_count;
        logic               list_nonempty;
        logic signed [31:0] front_key;
        logic signed [31:0] back_key;
    } dlle_rsp_t;

    typedef struct packed {
        logic [IDX_W-1:0]    rd_addr;
        logic [IDX_W-1:0]    free_rd_addr;
        logic                key_we;
        logic [IDX_W-1:0]    key_wa;
        logic [KEY_BITS-1:0] key_wd;
        logic                next_we;
        logic [IDX_W-1:0]    next_wa;
        logic [IDX_W-1:0]    next_wd;
        logic                prev_we;
        logic [IDX_W-1:0]    prev_wa;
        logic [IDX_W-1:0]    prev_wd;
        logic                free_we;
        logic [IDX_W-1:0]    free_wa;
        logic [IDX_W-1:0]    free_wd;
    } dlle_mem_req_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key_rd;
        logic [IDX_W-1:0]    next_rd;
        logic [IDX_W-1:0]    prev_rd;
        logic [IDX_W-1:0]    free_rd;
    } dlle_mem_rsp_t;

    function automatic logic [KEY_BITS-1:0] key_to_store(input logic [31:0] k);
        logic [63:0] w;
        w = {{32{k[31]}}, k};
        return w[KEY_BITS-1:0];
    endfunction

    function automatic logic [31:0] key_to_field(input logic [KEY_BITS-1:0] s);
        logic signed [63:0] w;
        w = 64'(signed'(s));
        return w[31:0];
    endfunction

endpackage

@@ sv/dlle_store.sv @@
`timescale 1ns / 1ps

module dlle_store
    import dlle_pkg::*;
(
    input  logic          clk,
    input  dlle_mem_req_t mem_req,
    output dlle_mem_rsp_t mem_rsp
);

    logic [KEY_BITS-1:0] key_mem  [CAPACITY];
    logic [IDX_W-1:0]    next_mem [CAPACITY];
    logic [IDX_W-1:0]    prev_mem [CAPACITY];
    logic [IDX_W-1:0]    free_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (mem_req.key_we)
        begin
            key_mem[mem_req.key_wa] <= mem_req.key_wd;
        end
        if (mem_req.next_we)
        begin
            next_mem[mem_req.next_wa] <= mem_req.next_wd;
        end
        if (mem_req.prev_we)
        begin
            prev_mem[mem_req.prev_wa] <= mem_req.prev_wd;
        end
        if (mem_req.free_we)
        begin
            free_mem[mem_req.free_wa] <= mem_req.free_wd;
        end
        mem_rsp.key_rd  <= key_mem[mem_req.rd_addr];
        mem_rsp.next_rd <= next_mem[mem_req.rd_addr];
        mem_rsp.prev_rd <= prev_mem[mem_req.rd_addr];
        mem_rsp.free_rd <= free_mem[mem_req.free_rd_addr];
    end

endmodule

@@ sv/doubly_linked_list_engine.sv @@
`timescale 1ns / 1ps
// A bounded doubly linked list of keys held in four single-port-read memories.
// Requests arrive on the req channel (kind, key) and each one returns exactly
// one transaction on the rsp channel: status, entry count and front/back keys.
// Both channels use valid/ready; a transaction moves when both are high.
// The block works on one request at a time. A request is taken only in the
// idle state; the result is loaded into an output register, so the next
// request can be taken while that result still waits for rsp_ready.
// Every request ends by reading the front and back keys (S_FH, S_FT) and
// loading the result in S_OUT. An ignored request (full list or empty
// delete) goes there straight from idle; an insert pops a freed slot from
// the free stack first (S_ALLOC) when one is there, then links the entry
// (S_INS); delete first or last reads and unlinks the end entry (S_UNL_RD, S_UNL).
// Delete by key walks from the head (S_WSTART, S_WALK); a found entry is
// unlinked as above. The walk reads one entry per cycle.
// If rsp_ready stays low, a finished result waits in the final state until
// the output register frees up.
// Reset empties the list at once; the memories need no clearing pass.

module doubly_linked_list_engine
    import dlle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dlle_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output dlle_rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_INS,
        S_WSTART,
        S_WALK,
        S_UNL_RD,
        S_UNL,
        S_FH,
        S_FT,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  free_top_reg, free_top_next;
    logic [COUNT_W-1:0]  fresh_reg, fresh_next;
    logic [COUNT_W-1:0]  walk_cnt_reg, walk_cnt_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    dlle_status_t        status_reg, status_next;
    logic [31:0]         front_key_reg, front_key_next;
    logic                rsp_valid_reg, rsp_valid_next;
    dlle_rsp_t           rsp_reg, rsp_next;

    dlle_mem_req_t       mem_req;
    dlle_mem_rsp_t       mem_rsp;
    logic [COUNT_W-1:0]  free_top_dec;

    dlle_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    assign req_ready    = (state_reg == S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign free_top_dec = free_top_reg - COUNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        free_top_next  = free_top_reg;
        fresh_next     = fresh_reg;
        walk_cnt_next  = walk_cnt_reg;
        slot_next      = slot_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        front_key_next = front_key_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        mem_req              = '0;
        mem_req.free_rd_addr = free_top_dec[IDX_W-1:0];

        case (state_reg)
            S_WSTART: mem_req.rd_addr = head_reg;
            S_WALK:   mem_req.rd_addr = mem_rsp.next_rd;
            S_UNL_RD: mem_req.rd_addr = slot_reg;
            S_FH:     mem_req.rd_addr = head_reg;
            S_FT:     mem_req.rd_addr = tail_reg;
            S_OUT:    mem_req.rd_addr = tail_reg;
            default:  mem_req.rd_addr = head_reg;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next    = key_to_store(req.key);
                    status_next = STATUS_DONE;
                    if (req.kind == OP_INSERT)
                    begin
                        if (count_reg == COUNT_W'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                            state_next  = S_FH;
                        end
                        else if (free_top_reg != '0)
                        begin
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            slot_next  = fresh_reg[IDX_W-1:0];
                            fresh_next = fresh_reg + COUNT_W'(1);
                            state_next = S_INS;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                        state_next  = S_FH;
                    end
                    else if (req.kind == OP_DEL_FIRST)
                    begin
                        slot_next  = head_reg;
                        state_next = S_UNL_RD;
                    end
                    else if (req.kind == OP_DEL_LAST)
                    begin
                        slot_next  = tail_reg;
                        state_next = S_UNL_RD;
                    end
                    else
                    begin
                        state_next = S_WSTART;
                    end
                end
            end
            S_ALLOC:
            begin
                slot_next     = mem_rsp.free_rd;
                free_top_next = free_top_dec;
                state_next    = S_INS;
            end
            S_INS:
            begin
                mem_req.key_we = 1'b1;
                mem_req.key_wa = slot_reg;
                mem_req.key_wd = key_reg;
                if (count_reg == '0)
                begin
                    tail_next = slot_reg;
                end
                else
                begin
                    mem_req.next_we = 1'b1;
                    mem_req.next_wa = slot_reg;
                    mem_req.next_wd = head_reg;
                    mem_req.prev_we = 1'b1;
                    mem_req.prev_wa = head_reg;
                    mem_req.prev_wd = slot_reg;
                end
                head_next  = slot_reg;
                count_next = count_reg + COUNT_W'(1);
                state_next = S_FH;
            end
            S_WSTART:
            begin
                slot_next     = head_reg;
                walk_cnt_next = '0;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (mem_rsp.key_rd == key_reg)
                begin
                    state_next = S_UNL_RD;
                end
                else if (walk_cnt_reg == count_reg - COUNT_W'(1))
                begin
                    status_next = STATUS_EMPTY;
                    state_next  = S_FH;
                end
                else
                begin
                    slot_next     = mem_rsp.next_rd;
                    walk_cnt_next = walk_cnt_reg + COUNT_W'(1);
                end
            end
            S_UNL_RD:
            begin
                state_next = S_UNL;
            end
            S_UNL:
            begin
                if (count_reg == COUNT_W'(1))
                begin
                    head_next = head_reg;
                end
                else if (slot_reg == head_reg)
                begin
                    head_next = mem_rsp.next_rd;
                end
                else if (slot_reg == tail_reg)
                begin
                    tail_next = mem_rsp.prev_rd;
                end
                else
                begin
                    mem_req.next_we = 1'b1;
                    mem_req.next_wa = mem_rsp.prev_rd;
                    mem_req.next_wd = mem_rsp.next_rd;
                    mem_req.prev_we = 1'b1;
                    mem_req.prev_wa = mem_rsp.next_rd;
                    mem_req.prev_wd = mem_rsp.prev_rd;
                end
                count_next = count_reg - COUNT_W'(1);
                if (free_top_reg < COUNT_W'(CAPACITY))
                begin
                    mem_req.free_we = 1'b1;
                    mem_req.free_wa = free_top_reg[IDX_W-1:0];
                    mem_req.free_wd = slot_reg;
                    free_top_next   = free_top_reg + COUNT_W'(1);
                end
                state_next = S_FH;
            end
            S_FH:
            begin
                state_next = S_FT;
            end
            S_FT:
            begin
                front_key_next = (count_reg != '0) ? key_to_field(mem_rsp.key_rd) : '0;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.entry_count   = 9'(count_reg);
                    rsp_next.list_nonempty = (count_reg != '0);
                    rsp_next.front_key     = front_key_reg;
                    rsp_next.back_key      = (count_reg != '0) ?
                                             key_to_field(mem_rsp.key_rd) : '0;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_top_reg  <= '0;
            fresh_reg     <= '0;
            walk_cnt_reg  <= '0;
            slot_reg      <= '0;
            key_reg       <= '0;
            status_reg    <= STATUS_DONE;
            front_key_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_top_reg  <= free_top_next;
            fresh_reg     <= fresh_next;
            walk_cnt_reg  <= walk_cnt_next;
            slot_reg      <= slot_next;
            key_reg       <= key_next;
            status_reg    <= status_next;
            front_key_reg <= front_key_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

@@ sv/dlle_checker.sv @@
`timescale 1ns / 1ps

module dlle_checker
    import dlle_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input dlle_rsp_t rsp
);

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("Result changed or dropped while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.list_nonempty == (rsp.entry_count != '0)))
    else $error("Nonempty flag disagrees with the entry count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.list_nonempty |-> rsp.front_key == '0 && rsp.back_key == '0)
    else $error("Empty list reports nonzero keys.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_FULL |-> rsp.entry_count == 9'(CAPACITY))
    else $error("Full status reported on a list that is not full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("A new transaction was taken while one is still in flight.");

endmodule

bind doubly_linked_list_engine dlle_checker u_dlle_checker (.*);

@@ tb/doubly_linked_list_engine_tb.sv @@
`timescale 1ns / 1ps

module doubly_linked_list_engine_tb;
    import dlle_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int POOL_SIZE = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    dlle_req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    dlle_rsp_t rsp;

    dlle_req_t queued_requests[$];
    dlle_rsp_t list_reports[$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int recv_stall = 0;
    logic signed [31:0] key_pool[POOL_SIZE];

    logic [KEY_BITS-1:0] list_keys[CAPACITY];
    logic [IDX_W-1:0] fwd_link[CAPACITY];
    logic [IDX_W-1:0] back_link[CAPACITY];
    logic [IDX_W-1:0] free_slots[CAPACITY];
    int free_depth = 0;
    int fresh_slot = 0;
    logic [IDX_W-1:0] front_slot = '0;
    logic [IDX_W-1:0] back_slot = '0;
    int live_count = 0;

    doubly_linked_list_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic void unlink_entry(logic [IDX_W-1:0] s);
        if (live_count > 1)
        begin
            if (s == front_slot)
            begin
                front_slot = fwd_link[s];
            end
            else if (s == back_slot)
            begin
                back_slot = back_link[s];
            end
            else
            begin
                fwd_link[back_link[s]] = fwd_link[s];
                back_link[fwd_link[s]] = back_link[s];
            end
        end
        live_count--;
        if (free_depth < CAPACITY)
        begin
            free_slots[IDX_W'(free_depth)] = s;
            free_depth++;
        end
    endfunction

    function automatic dlle_rsp_t apply_list_op(dlle_req_t r);
        dlle_rsp_t out;
        logic [KEY_BITS-1:0] k;
        logic [IDX_W-1:0] s;
        int n;
        bit found;
        out = '0;
        out.status = STATUS_DONE;
        k = KEY_BITS'(r.key);
        if (r.kind == OP_INSERT)
        begin
            if (live_count >= CAPACITY)
            begin
                out.status = STATUS_FULL;
            end
            else
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    s = free_slots[IDX_W'(free_depth)];
                end
                else
                begin
                    s = IDX_W'(fresh_slot);
                    fresh_slot++;
                end
                list_keys[s] = k;
                if (live_count == 0)
                begin
                    back_slot = s;
                end
                else
                begin
                    fwd_link[s] = front_slot;
                    back_link[front_slot] = s;
                end
                front_slot = s;
                live_count++;
            end
        end
        else if (live_count == 0)
        begin
            out.status = STATUS_EMPTY;
        end
        else if (r.kind == OP_DEL_FIRST)
        begin
            unlink_entry(front_slot);
        end
        else if (r.kind == OP_DEL_LAST)
        begin
            unlink_entry(back_slot);
        end
        else
        begin
            s = front_slot;
            n = 0;
            found = 1'b0;
            while (!found && n < live_count)
            begin
                if (list_keys[s] == k)
                begin
                    found = 1'b1;
                end
                else
                begin
                    s = fwd_link[s];
                    n++;
                end
            end
            if (found)
            begin
                unlink_entry(s);
            end
            else
            begin
                out.status = STATUS_EMPTY;
            end
        end
        out.entry_count = 9'(live_count);
        if (live_count > 0)
        begin
            out.list_nonempty = 1'b1;
            out.front_key = 32'(signed'(list_keys[front_slot]));
            out.back_key = 32'(signed'(list_keys[back_slot]));
        end
        return out;
    endfunction

    function automatic bit all_settled();
        return queued_requests.size() == 0 && !req_valid && list_reports.size() == 0;
    endfunction

    function automatic void queue_op(dlle_op_t kind, logic signed [31:0] key);
        dlle_req_t r;
        r.kind = kind;
        r.key = key;
        queued_requests.push_back(r);
    endfunction

    function automatic dlle_req_t random_op(int insert_pct);
        dlle_req_t r;
        r.key = $urandom();
        if ($urandom_range(0, 99) < insert_pct)
        begin
            r.kind = OP_INSERT;
            if ($urandom_range(0, 99) < 60)
            begin
                r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: r.kind = OP_DEL_FIRST;
                1: r.kind = OP_DEL_LAST;
                default: r.kind = OP_DEL_KEY;
            endcase
            if (r.kind == OP_DEL_KEY && $urandom_range(0, 99) < 75)
            begin
                r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
        end
        return r;
    endfunction

    task automatic run_phase(int count, int insert_pct, int idle_pct);
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            queued_requests.push_back(random_op(insert_pct));
        end
        while (queued_requests.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                list_reports.push_back(apply_list_op(req));
            end
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() == 0)
                begin
                    req_valid <= 1'b0;
                end
                else if ($urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap <= $urandom_range(0, 5);
                    req_valid <= 1'b0;
                end
                else
                begin
                    req <= queued_requests.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        dlle_rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (list_reports.size() == 0)
                begin
                    $error("unexpected transaction: %p", rsp);
                    error_count++;
                end
                else
                begin
                    want = list_reports.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, rsp.entry_count);
                        error_count++;
                    end
                    if (rsp.list_nonempty !== want.list_nonempty)
                    begin
                        $error("list_nonempty mismatch: expected %0d, actual %0d",
                               want.list_nonempty, rsp.list_nonempty);
                        error_count++;
                    end
                    if (rsp.front_key !== want.front_key)
                    begin
                        $error("front_key mismatch: expected %0d, actual %0d",
                               want.front_key, rsp.front_key);
                        error_count++;
                    end
                    if (rsp.back_key !== want.back_key)
                    begin
                        $error("back_key mismatch: expected %0d, actual %0d",
                               want.back_key, rsp.back_key);
                        error_count++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                rsp_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_stall <= $urandom_range(0, 5);
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        key_pool[0] = 32'sh7fffffff;
        key_pool[1] = 32'sh80000000;
        key_pool[2] = 32'sh0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 30;
        queue_op(OP_DEL_FIRST, 32'sh0);
        queue_op(OP_DEL_LAST, -32'sd1);
        queue_op(OP_DEL_KEY, 32'sh0);
        queue_op(OP_INSERT, 32'sh7fffffff);
        queue_op(OP_INSERT, 32'sh80000000);
        queue_op(OP_INSERT, 32'sh0);
        queue_op(OP_INSERT, -32'sd1);
        queue_op(OP_INSERT, 32'sd5);
        queue_op(OP_INSERT, 32'sd5);
        queue_op(OP_INSERT, 32'sd9);
        queue_op(OP_DEL_KEY, 32'sd5);
        queue_op(OP_DEL_KEY, 32'sd12345);
        queue_op(OP_DEL_KEY, 32'sd9);
        queue_op(OP_DEL_KEY, 32'sh7fffffff);
        queue_op(OP_DEL_KEY, 32'sh0);
        queue_op(OP_DEL_FIRST, 32'sh0);
        queue_op(OP_DEL_LAST, 32'sh0);
        queue_op(OP_DEL_KEY, -32'sd1);
        queue_op(OP_DEL_LAST, 32'sh0);
        queue_op(OP_INSERT, 32'sd1);
        queue_op(OP_DEL_LAST, 32'sh0);
        queue_op(OP_INSERT, 32'sh55555555);
        queue_op(OP_DEL_KEY, 32'sh55555555);

        // Hold off new requests until every outstanding transaction has returned.
        while (!all_settled())
        begin
            @(posedge clk);
        end

        run_phase(500, 55, 30);
        run_phase(450, 90, 20);
        run_phase(150, 50, 0);
        run_phase(400, 15, 35);
        run_phase(200, 50, 40);
        run_phase(150, 50, 0);

        while (!all_settled())
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && list_reports.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
